[design/utf8dw_pkg.sv]
// Shared types, constants and the cell-width lookup for the UTF-8 width/placement block.
package utf8dw_pkg;

    localparam int COUNT_BITS_DEF = 12;
    localparam int CFG_BITS       = 10;
    localparam int CFG_IDX_BITS   = 3;

    localparam logic [11:0] OUT12_MAX = 12'hFFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_PANEL_X      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PANEL_Y      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PANEL_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PANEL_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ALIGNMENT    = 3'd4;

    localparam logic [9:0] PANEL_WIDTH_RST  = 10'd80;
    localparam logic [9:0] PANEL_HEIGHT_RST = 10'd24;

    typedef enum logic [1:0] {
        REQ_BYTE = 2'd0,
        REQ_EOL  = 2'd1,
        REQ_EOF  = 2'd2
    } t_req_e;

    typedef enum logic [1:0] {
        ALIGN_LEFT   = 2'd0,
        ALIGN_CENTER = 2'd1,
        ALIGN_RIGHT  = 2'd2
    } t_align_e;

    typedef struct packed {
        t_req_e     req_type;
        logic [7:0] byte_value;
    } t_in_req;

    typedef struct packed {
        logic [10:0] start_x;
        logic [10:0] start_y;
        logic [11:0] art_width;
        logic [11:0] art_height;
        logic [11:0] lines_shown;
        logic        oversize;
        logic        drawable;
    } t_out_res;

    // Display cells of one code point: 2 for Hangul and CJK, 1 otherwise
    function automatic logic [1:0] cell_width(input logic [20:0] cp);
        logic wide;
        wide = ((cp >= 21'h00AC00) && (cp <= 21'h00D7A3))
            || ((cp >= 21'h001100) && (cp <= 21'h0011FF))
            || ((cp >= 21'h003130) && (cp <= 21'h00318F))
            || ((cp >= 21'h004E00) && (cp <= 21'h009FFF))
            || ((cp >= 21'h003400) && (cp <= 21'h004DBF))
            || ((cp >= 21'h00F900) && (cp <= 21'h00FAFF));
        return wide ? 2'd2 : 2'd1;
    endfunction

endpackage

[design/utf8_display_width_placement.sv]
// Top level: UTF-8 display width measurement and panel placement per text frame.
//
//   channel  | dir | handshake                    | payload
//   ---------+-----+------------------------------+----------------------------
//   request  | in  | i_in_valid / o_in_ready      | i_in  (t_in_req)
//   result   | out | o_out_valid / i_out_ready    | o_out (t_out_res)
//   config   | in  | i_cfg_we, no wait            | i_cfg_idx, i_cfg_data
//
// One request per cycle. Text bytes and end-of-line update the line counters
// at the edge they are taken; end-of-frame loads a frame summary register, and
// the placement computed from that summary then lands in the result register.
// Synchronous active-low reset clears the counters and the pipeline valids and
// loads the register defaults. A stalled result holds the summary stage; requests
// stop only while both the summary and result stages are full and the result is
// not being taken.
module utf8_display_width_placement #(
    parameter int COUNT_BITS = utf8dw_pkg::COUNT_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  utf8dw_pkg::t_in_req                   i_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output utf8dw_pkg::t_out_res                  o_out,
    input  logic                                  i_cfg_we,
    input  logic [utf8dw_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [utf8dw_pkg::CFG_BITS-1:0]       i_cfg_data
);
    import utf8dw_pkg::*;

    logic [9:0] r_panel_x, r_panel_y, r_panel_width, r_panel_height;
    logic [1:0] r_alignment;

    logic                  take;
    logic                  eof;
    logic [COUNT_BITS-1:0] frame_widest, frame_count;
    logic                  r_sum_valid;
    logic [COUNT_BITS-1:0] r_sum_widest, r_sum_count;
    logic                  out_adv, sum_adv;
    t_out_res              placed;
    t_out_res              r_out;
    logic                  r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_panel_x      <= 10'd0;
            r_panel_y      <= 10'd0;
            r_panel_width  <= PANEL_WIDTH_RST;
            r_panel_height <= PANEL_HEIGHT_RST;
            r_alignment    <= ALIGN_LEFT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PANEL_X:      r_panel_x      <= i_cfg_data;
                CFG_PANEL_Y:      r_panel_y      <= i_cfg_data;
                CFG_PANEL_WIDTH:  r_panel_width  <= i_cfg_data;
                CFG_PANEL_HEIGHT: r_panel_height <= i_cfg_data;
                CFG_ALIGNMENT:    r_alignment    <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    assign out_adv    = !r_out_valid || i_out_ready;
    assign sum_adv    = r_sum_valid && out_adv;
    assign o_in_ready = !r_sum_valid || out_adv;
    assign take       = i_in_valid && o_in_ready;

    utf8dw_track #(
        .COUNT_BITS (COUNT_BITS)
    ) u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_req    (i_in),
        .o_eof    (eof),
        .o_widest (frame_widest),
        .o_count  (frame_count)
    );

    // frame summary stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid <= 1'b0;
        end else if (eof) begin
            r_sum_valid <= 1'b1;
        end else if (sum_adv) begin
            r_sum_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eof) begin
            r_sum_widest <= frame_widest;
            r_sum_count  <= frame_count;
        end
    end

    utf8dw_place #(
        .COUNT_BITS (COUNT_BITS)
    ) u_place (
        .i_widest       (r_sum_widest),
        .i_count        (r_sum_count),
        .i_panel_x      (r_panel_x),
        .i_panel_y      (r_panel_y),
        .i_panel_width  (r_panel_width),
        .i_panel_height (r_panel_height),
        .i_alignment    (r_alignment),
        .o_res          (placed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_sum_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sum_adv) begin
            r_out <= placed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[design/utf8dw_track.sv]
// UTF-8 decode and per-frame line width / line count tracking.
module utf8dw_track #(
    parameter int COUNT_BITS = utf8dw_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  utf8dw_pkg::t_in_req   i_req,
    output logic                  o_eof,
    output logic [COUNT_BITS-1:0] o_widest,
    output logic [COUNT_BITS-1:0] o_count
);
    import utf8dw_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [1:0]            r_bytes_left, n_bytes_left;
    logic [20:0]           r_code_accum, n_code_accum;
    logic [COUNT_BITS-1:0] r_line_cells, n_line_cells;
    logic [COUNT_BITS-1:0] r_widest,     n_widest;
    logic [COUNT_BITS-1:0] r_count,      n_count;

    logic [20:0]           cont_cp;
    logic [1:0]            byte_w;
    logic [COUNT_BITS:0]   cells_sum;
    logic [COUNT_BITS-1:0] cells_byte;
    logic [COUNT_BITS:0]   flush_sum;
    logic [COUNT_BITS-1:0] cells_flushed;
    logic [COUNT_BITS:0]   count_sum;
    logic [COUNT_BITS-1:0] widest_closed;
    logic [COUNT_BITS-1:0] count_closed;
    logic [7:0]            b;

    assign b       = i_req.byte_value;
    assign cont_cp = {r_code_accum[14:0], b[5:0]};

    // cells added by this byte (0 while a sequence is still open)
    always_comb begin
        byte_w = 2'd0;
        if (r_bytes_left != 2'd0) begin
            if (r_bytes_left == 2'd1) begin
                byte_w = cell_width(cont_cp);
            end
        end else if (!b[7] || (b[7:6] == 2'b10) || (b[7:3] == 5'b11111)) begin
            byte_w = 2'd1;
        end
    end

    assign cells_sum  = {1'b0, r_line_cells} + (COUNT_BITS+1)'(byte_w);
    assign cells_byte = cells_sum[COUNT_BITS] ? CNT_MAX : cells_sum[COUNT_BITS-1:0];

    // closing a line: a truncated sequence counts as one narrow cell
    assign flush_sum     = {1'b0, r_line_cells} + (COUNT_BITS+1)'(r_bytes_left != 2'd0);
    assign cells_flushed = flush_sum[COUNT_BITS] ? CNT_MAX : flush_sum[COUNT_BITS-1:0];
    assign widest_closed = (cells_flushed > r_widest) ? cells_flushed : r_widest;
    assign count_sum     = {1'b0, r_count} + (COUNT_BITS+1)'(1);
    assign count_closed  = count_sum[COUNT_BITS] ? CNT_MAX : count_sum[COUNT_BITS-1:0];

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_code_accum = r_code_accum;
        n_line_cells = r_line_cells;
        n_widest     = r_widest;
        n_count      = r_count;
        o_eof        = 1'b0;
        o_widest     = r_widest;
        o_count      = r_count;
        if (i_take) begin
            case (i_req.req_type)
                REQ_BYTE: begin
                    n_line_cells = cells_byte;
                    if (r_bytes_left != 2'd0) begin
                        n_bytes_left = r_bytes_left - 2'd1;
                        n_code_accum = (r_bytes_left == 2'd1) ? 21'd0 : cont_cp;
                    end else if (b[7:5] == 3'b110) begin
                        n_code_accum = {16'd0, b[4:0]};
                        n_bytes_left = 2'd1;
                    end else if (b[7:4] == 4'b1110) begin
                        n_code_accum = {17'd0, b[3:0]};
                        n_bytes_left = 2'd2;
                    end else if (b[7:3] == 5'b11110) begin
                        n_code_accum = {18'd0, b[2:0]};
                        n_bytes_left = 2'd3;
                    end
                end
                REQ_EOL: begin
                    n_bytes_left = 2'd0;
                    n_code_accum = 21'd0;
                    n_line_cells = '0;
                    n_widest     = widest_closed;
                    n_count      = count_closed;
                end
                REQ_EOF: begin
                    o_eof = 1'b1;
                    // an unterminated last line still counts
                    if ((r_line_cells != '0) || (r_bytes_left != 2'd0)) begin
                        o_widest = widest_closed;
                        o_count  = count_closed;
                    end
                    n_bytes_left = 2'd0;
                    n_code_accum = 21'd0;
                    n_line_cells = '0;
                    n_widest     = '0;
                    n_count      = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= 2'd0;
            r_code_accum <= 21'd0;
            r_line_cells <= '0;
            r_widest     <= '0;
            r_count      <= '0;
        end else begin
            r_bytes_left <= n_bytes_left;
            r_code_accum <= n_code_accum;
            r_line_cells <= n_line_cells;
            r_widest     <= n_widest;
            r_count      <= n_count;
        end
    end

endmodule

[design/utf8dw_place.sv]
// Panel placement of a finished frame: start position, visible lines and flags.
module utf8dw_place #(
    parameter int COUNT_BITS = utf8dw_pkg::COUNT_BITS_DEF
) (
    input  logic [COUNT_BITS-1:0] i_widest,
    input  logic [COUNT_BITS-1:0] i_count,
    input  logic [9:0]            i_panel_x,
    input  logic [9:0]            i_panel_y,
    input  logic [9:0]            i_panel_width,
    input  logic [9:0]            i_panel_height,
    input  logic [1:0]            i_alignment,
    output utf8dw_pkg::t_out_res  o_res
);
    import utf8dw_pkg::*;

    localparam int SW = ((COUNT_BITS > 11) ? COUNT_BITS : 11) + 2;
    localparam int EW = (COUNT_BITS > 12) ? COUNT_BITS : 12;
    localparam logic signed [SW-1:0] S_ONE = SW'(1);
    localparam logic signed [SW-1:0] S_TWO = SW'(2);
    localparam logic signed [SW-1:0] S_ZERO = '0;

    logic signed [SW-1:0] cx, cy, cw, ch, aw, ah;
    logic signed [SW-1:0] diff_x, diff_y, sx, sy, room, shown;
    logic [EW-1:0]        ext_w, ext_h;
    logic                 drawable;

    assign cx = $signed(SW'(i_panel_x)) + S_ONE;
    assign cy = $signed(SW'(i_panel_y)) + S_ONE;
    assign cw = $signed(SW'(i_panel_width)) - S_TWO;
    assign ch = $signed(SW'(i_panel_height)) - S_TWO;
    assign aw = $signed(SW'(i_widest));
    assign ah = $signed(SW'(i_count));

    assign drawable = (i_count != '0) && (cw > S_ZERO) && (ch > S_ZERO);
    assign diff_x   = cw - aw;
    assign diff_y   = ch - ah;

    always_comb begin
        sx = cx;
        sy = cy;
        case (t_align_e'(i_alignment))
            ALIGN_CENTER: begin
                if (cw > aw) sx = cx + (diff_x >>> 1);
                if (ch > ah) sy = cy + (diff_y >>> 1);
            end
            ALIGN_RIGHT: begin
                if (cw > aw) sx = cx + diff_x;
            end
            default: begin
            end
        endcase
    end

    assign room  = cy + ch - sy;
    assign shown = (ah < room) ? ah : room;

    assign ext_w = EW'(i_widest);
    assign ext_h = EW'(i_count);

    always_comb begin
        o_res.art_width  = (ext_w > EW'(OUT12_MAX)) ? OUT12_MAX : ext_w[11:0];
        o_res.art_height = (ext_h > EW'(OUT12_MAX)) ? OUT12_MAX : ext_h[11:0];
        o_res.drawable   = drawable;
        o_res.start_x    = 11'd0;
        o_res.start_y    = 11'd0;
        o_res.lines_shown = 12'd0;
        o_res.oversize   = 1'b0;
        if (drawable) begin
            o_res.start_x = sx[10:0];
            o_res.start_y = sy[10:0];
            // room never exceeds the content height, so 12 bits hold it
            o_res.lines_shown = (shown < S_ZERO) ? 12'd0 : shown[11:0];
            o_res.oversize = (ah > ch) || (aw > cw);
        end
    end

endmodule

[dv/utf8_display_width_placement_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the UTF-8 width/placement block: tracks each text frame and checks its summary.
module utf8_display_width_placement_checker #(
    parameter int COUNT_BITS = utf8dw_pkg::COUNT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  utf8dw_pkg::t_in_req                 i_in,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  utf8dw_pkg::t_out_res                i_out,
    input  logic                                i_cfg_we,
    input  logic [utf8dw_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [utf8dw_pkg::CFG_BITS-1:0]     i_cfg_data,
    output int                                  o_mismatches,
    output int                                  o_pending
);
    import utf8dw_pkg::*;

    localparam int unsigned CELL_SAT = (1 << COUNT_BITS) - 1;

    logic [9:0] pan_x, pan_y, pan_w, pan_h;
    logic [1:0] pan_align;

    int unsigned cont_due;
    int unsigned cp_acc;
    int unsigned line_cells;
    int unsigned widest;
    int unsigned n_lines;

    t_out_res summaries_due[$];
    int       summaries_seen;

    task automatic flag_mismatch(input string what);
        o_mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic int unsigned glyph_cells(input int unsigned cp);
        if (cp >= 'hAC00 && cp <= 'hD7A3) return 2;  // Hangul syllables
        if (cp >= 'h1100 && cp <= 'h11FF) return 2;  // jamo
        if (cp >= 'h3130 && cp <= 'h318F) return 2;  // compatibility jamo
        if (cp >= 'h3400 && cp <= 'h4DBF) return 2;
        if (cp >= 'h4E00 && cp <= 'h9FFF) return 2;
        if (cp >= 'hF900 && cp <= 'hFAFF) return 2;
        return 1;                                    // Braille and the rest
    endfunction

    function automatic void add_cells(input int unsigned w);
        line_cells = (line_cells + w > CELL_SAT) ? CELL_SAT : line_cells + w;
    endfunction

    function automatic void clear_frame();
        cont_due   = 0;
        cp_acc     = 0;
        line_cells = 0;
        widest     = 0;
        n_lines    = 0;
    endfunction

    function automatic void close_line();
        // a sequence cut short still takes one cell
        if (cont_due != 0) begin
            add_cells(1);
            cont_due = 0;
            cp_acc   = 0;
        end
        if (line_cells > widest) widest = line_cells;
        if (n_lines < CELL_SAT) n_lines++;
        line_cells = 0;
    endfunction

    function automatic void take_byte(input logic [7:0] b);
        if (cont_due != 0) begin
            // no check on the continuation marker bits
            cp_acc = ((cp_acc << 6) | b[5:0]) & 'h1FFFFF;
            cont_due--;
            if (cont_due == 0) begin
                add_cells(glyph_cells(cp_acc));
                cp_acc = 0;
            end
        end else if (!b[7]) begin
            add_cells(1);
        end else if (b[7:5] == 3'b110) begin
            cp_acc   = b[4:0];
            cont_due = 1;
        end else if (b[7:4] == 4'b1110) begin
            cp_acc   = b[3:0];
            cont_due = 2;
        end else if (b[7:3] == 5'b11110) begin
            cp_acc   = b[2:0];
            cont_due = 3;
        end else begin
            add_cells(1);  // bad lead: code point zero
        end
    endfunction

    function automatic t_out_res frame_summary();
        int       cx, cy, cw, ch, aw, ah, sx, sy, room, shown;
        bit       drawable;
        t_out_res s;
        if (line_cells != 0 || cont_due != 0) close_line();
        cx = int'(pan_x) + 1;
        cy = int'(pan_y) + 1;
        cw = int'(pan_w) - 2;
        ch = int'(pan_h) - 2;
        aw = int'(widest);
        ah = int'(n_lines);
        drawable = n_lines != 0 && cw > 0 && ch > 0;
        sx = 0;
        sy = 0;
        shown = 0;
        if (drawable) begin
            sx = cx;
            sy = cy;
            // oversized art stays pinned to the top left of the content area
            if (pan_align == ALIGN_CENTER) begin
                if (cw > aw) sx = cx + (cw - aw) / 2;
                if (ch > ah) sy = cy + (ch - ah) / 2;
            end else if (pan_align == ALIGN_RIGHT) begin
                if (cw > aw) sx = cx + cw - aw;
            end
            room  = cy + ch - sy;
            shown = (ah < room) ? ah : room;
            if (shown < 0) shown = 0;
        end
        s.start_x     = 11'(sx);
        s.start_y     = 11'(sy);
        s.art_width   = (widest > OUT12_MAX) ? OUT12_MAX : 12'(widest);
        s.art_height  = (n_lines > OUT12_MAX) ? OUT12_MAX : 12'(n_lines);
        s.lines_shown = (shown > OUT12_MAX) ? OUT12_MAX : 12'(shown);
        s.oversize    = drawable && (ah > ch || aw > cw);
        s.drawable    = drawable;
        clear_frame();
        return s;
    endfunction

    task automatic check_field(input string name, input logic [11:0] got,
                               input logic [11:0] want);
        if (got !== want)
            flag_mismatch($sformatf("summary %0d %s: got %0d, want %0d",
                                    summaries_seen, name, got, want));
    endtask

    task automatic compare_summary(input t_out_res want);
        if (i_out !== want) begin
            check_field("start_x", i_out.start_x, want.start_x);
            check_field("start_y", i_out.start_y, want.start_y);
            check_field("art_width", i_out.art_width, want.art_width);
            check_field("art_height", i_out.art_height, want.art_height);
            check_field("lines_shown", i_out.lines_shown, want.lines_shown);
            check_field("oversize", i_out.oversize, want.oversize);
            check_field("drawable", i_out.drawable, want.drawable);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pan_x     = '0;
            pan_y     = '0;
            pan_w     = PANEL_WIDTH_RST;
            pan_h     = PANEL_HEIGHT_RST;
            pan_align = ALIGN_LEFT;
            clear_frame();
            summaries_due.delete();
            summaries_seen = 0;
            o_mismatches   = 0;
            o_pending      = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PANEL_X:      pan_x = i_cfg_data;
                    CFG_PANEL_Y:      pan_y = i_cfg_data;
                    CFG_PANEL_WIDTH:  pan_w = i_cfg_data;
                    CFG_PANEL_HEIGHT: pan_h = i_cfg_data;
                    CFG_ALIGNMENT:    pan_align = i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                case (i_in.req_type)
                    REQ_BYTE: take_byte(i_in.byte_value);
                    REQ_EOL:  close_line();
                    REQ_EOF:  summaries_due.insert(summaries_due.size(), frame_summary());
                    default: ;  // spare request code is dropped
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                summaries_seen++;
                if (summaries_due.size() == 0)
                    flag_mismatch($sformatf("summary %0d arrived with none due", summaries_seen));
                else
                    compare_summary(summaries_due.pop_front());
            end
            o_pending = summaries_due.size();
        end
    end

endmodule

[dv/utf8_display_width_placement_tb.sv]
`timescale 1ns / 100ps
// Testbench top: feeds text frames and panel settings to the UTF-8 width/placement block.
module utf8_display_width_placement_tb;
    import utf8dw_pkg::*;

    localparam logic [1:0]              REQ_SPARE    = 2'd3;
    localparam logic [1:0]              ALIGN_SPARE  = 2'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED = 3'd7;
    localparam int                      STALL_LIMIT  = 2000;

    localparam logic [CFG_IDX_BITS-1:0] REG_ORDER [5] = '{
        CFG_PANEL_X, CFG_PANEL_Y, CFG_PANEL_WIDTH, CFG_PANEL_HEIGHT, CFG_ALIGNMENT
    };

    // both sides of every wide range boundary
    localparam logic [20:0] WIDTH_EDGES [28] = '{
        21'h27FF, 21'h2800, 21'h28FF, 21'h2900, 21'hABFF, 21'hAC00, 21'hD7A3, 21'hD7A4,
        21'h10FF, 21'h1100, 21'h11FF, 21'h1200, 21'h312F, 21'h3130, 21'h318F, 21'h3190,
        21'h4DFF, 21'h4E00, 21'h9FFF, 21'hA000, 21'h33FF, 21'h3400, 21'h4DBF, 21'h4DC0,
        21'hF8FF, 21'hF900, 21'hFAFF, 21'hFB00
    };

    localparam int READY_PCT [4] = '{100, 70, 30, 10};

    logic                    clk;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    t_in_req                 in_req    = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    t_out_res                out_res;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_idx   = '0;
    logic [CFG_BITS-1:0]     cfg_data  = '0;

    int mismatches;
    int pending;

    t_in_req     req_q[$];
    int          burst_left  = 0;
    int unsigned ready_pct   = 100;
    int unsigned ready_span  = 0;
    int          idle_cycles = 0;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    utf8_display_width_placement i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_res),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    utf8_display_width_placement_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_req),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_res),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // result side: spans of differing readiness
    always @(negedge clk) begin
        if (ready_span == 0) begin
            ready_pct  <= READY_PCT[$urandom_range(0, 3)];
            ready_span <= $urandom_range(10, 80);
        end else begin
            ready_span <= ready_span - 1;
        end
        out_ready <= ($urandom_range(1, 100) <= ready_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic void put_byte(input logic [7:0] b);
        t_in_req r;
        r.req_type   = REQ_BYTE;
        r.byte_value = b;
        req_q.insert(req_q.size(), r);
    endfunction

    function automatic void put_mark(input logic [1:0] kind);
        t_in_req r;
        r.req_type   = t_req_e'(kind);
        r.byte_value = 8'($urandom);  // don't care on marks
        req_q.insert(req_q.size(), r);
    endfunction

    function automatic void put_cp(input logic [20:0] cp);
        if (cp < 21'h80) begin
            put_byte({1'b0, cp[6:0]});
        end else if (cp < 21'h800) begin
            put_byte({3'b110, cp[10:6]});
            put_byte({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            put_byte({4'b1110, cp[15:12]});
            put_byte({2'b10, cp[11:6]});
            put_byte({2'b10, cp[5:0]});
        end else begin
            put_byte({5'b11110, cp[20:18]});
            put_byte({2'b10, cp[17:12]});
            put_byte({2'b10, cp[11:6]});
            put_byte({2'b10, cp[5:0]});
        end
    endfunction

    function automatic logic [20:0] pick_glyph();
        case ($urandom_range(0, 7))
            0:       return WIDTH_EDGES[$urandom_range(0, 27)];
            1:       return 21'($urandom_range('h80, 'h7FF));
            2:       return 21'($urandom_range('h800, 'hFFFF));
            3:       return 21'($urandom_range('h10000, 'h1FFFFF));
            4:       return 21'($urandom_range('h4E00, 'h9FFF));
            5:       return 21'($urandom_range('hAC00, 'hD7A3));
            default: return 21'($urandom_range(0, 'h7F));
        endcase
    endfunction

    // mostly well-formed text, with some line noise, dangling leads and spare requests
    function automatic void add_frame(input int max_lines, input int max_glyphs);
        int n_lines;
        int n_glyphs;
        n_lines = $urandom_range(0, max_lines);
        for (int l = 0; l < n_lines; l++) begin
            n_glyphs = $urandom_range(0, max_glyphs);
            for (int g = 0; g < n_glyphs; g++) begin
                case ($urandom_range(0, 15))
                    0:       put_byte(8'($urandom));
                    1:       put_byte(8'($urandom_range('hC0, 'hF7)));
                    2:       put_mark(REQ_SPARE);
                    default: put_cp(pick_glyph());
                endcase
            end
            // last line sometimes left open
            if (l < n_lines - 1 || $urandom_range(0, 2) != 0) put_mark(REQ_EOL);
        end
        put_mark(REQ_EOF);
    endfunction

    function automatic logic [9:0] pick_pos();
        case ($urandom_range(0, 3))
            0:       return 10'd0;
            1:       return 10'd1023;
            default: return 10'($urandom);
        endcase
    endfunction

    function automatic logic [9:0] pick_extent();
        case ($urandom_range(0, 5))
            0:       return 10'($urandom_range(0, 3));
            1:       return 10'($urandom);
            2:       return 10'd1023;
            default: return 10'($urandom_range(4, 30));
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic push_req(input t_in_req r);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 150)
                                                     : $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        burst_left--;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_all();
        while (req_q.size() != 0) push_req(req_q.pop_front());
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic program_panel(input logic [9:0] x, y, w, h, input logic [1:0] al,
                                 input bit stray);
        logic [9:0] vals [5];
        vals[0] = x;
        vals[1] = y;
        vals[2] = w;
        vals[3] = h;
        vals[4] = {8'($urandom), al};
        for (int k = 0; k < 5; k++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= REG_ORDER[k];
            cfg_data <= vals[k];
            @(negedge clk);
        end
        if (stray) begin
            cfg_idx  <= CFG_UNMAPPED;
            cfg_data <= 10'($urandom);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_phase(input int budget, input int max_lines, input int max_glyphs);
        while (req_q.size() < budget) add_frame(max_lines, max_glyphs);
        send_all();
        wait_drained();
    endtask

    initial begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed frames under the reset panel
        put_byte(8'h00);
        put_byte(8'h7F);
        put_cp(21'h80);
        put_cp(21'h4E00);
        put_cp(21'h1F600);
        put_byte(8'h80);         // continuation with no sequence open
        put_byte(8'hF8);
        put_byte(8'hFF);
        put_mark(REQ_EOL);
        put_byte(8'hE2);
        put_byte(8'hA0);         // cut short by the end of line
        put_mark(REQ_SPARE);
        put_mark(REQ_EOL);
        put_mark(REQ_EOF);
        put_mark(REQ_EOF);       // empty frame
        put_byte(8'h41);
        put_mark(REQ_EOF);       // last line never closed
        put_byte(8'hC3);
        put_mark(REQ_EOF);       // sequence still open at end of frame
        put_byte(8'h41);
        put_mark(REQ_EOL);
        put_mark(REQ_EOF);       // no extra empty line after a closed one
        send_all();
        wait_drained();

        // panel extremes
        program_panel(10'd0, 10'd0, 10'd0, 10'd0, ALIGN_CENTER, 1'b1);
        run_phase(60, 4, 6);
        program_panel(10'd1023, 10'd1023, 10'd1023, 10'd1023, ALIGN_RIGHT, 1'b0);
        run_phase(60, 4, 6);
        program_panel(10'd5, 10'd9, 10'd3, 10'd3, ALIGN_CENTER, 1'b0);
        run_phase(60, 3, 4);
        program_panel(10'd1023, 10'd0, 10'd2, 10'd40, ALIGN_RIGHT, 1'b0);
        run_phase(60, 4, 6);
        program_panel(10'd0, 10'd1023, 10'd40, 10'd2, ALIGN_SPARE, 1'b0);
        run_phase(60, 4, 6);
        program_panel(10'd17, 10'd4, 10'd12, 10'd6, ALIGN_CENTER, 1'b0);
        run_phase(60, 6, 8);
        program_panel(10'd1, 10'd1, 10'd1, 10'd1, ALIGN_LEFT, 1'b0);
        run_phase(60, 4, 6);

        for (int p = 0; p < 9; p++) begin
            program_panel(pick_pos(), pick_pos(), pick_extent(), pick_extent(),
                          2'($urandom), 1'b0);
            run_phase(80, 5, 8);
        end

        repeat (8) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
